>>> sv/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// shared types, codes and defaults of the escape sequence decoder
// ----------------------------------------------------------------------------
package eds_pkg;

   localparam int ENTITY_NAME_MAX_DEF = 31;
   localparam int COUNT_WIDTH_DEF     = 16;
   localparam int HCNT_W              = 6;
   localparam int CSR_ADDR_W          = 4;

   localparam logic [1:0] REG_DECODE_MODES  = 2'd0;
   localparam logic [1:0] REG_STOP_CHAR     = 2'd1;
   localparam logic [1:0] REG_MAX_OUT_BYTES = 2'd2;

   localparam logic [15:0] MAX_OUT_RESET = 16'hffff;

   localparam int MODE_PERCENT   = 0;
   localparam int MODE_BACKSLASH = 1;
   localparam int MODE_AMPERSAND = 2;
   localparam int MODE_PLUS      = 3;
   localparam int MODE_EQUALS    = 4;

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_HEX_A,
      PS_HEX_B,
      PS_BSL,
      PS_OCT,
      PS_AMP
   } parse_type;

   typedef enum logic [1:0] {
      PTR_ADVANCE,
      PTR_REPLAY,
      PTR_REDO
   } ptr_op_type;

   typedef struct packed {
      parse_type           parse;
      logic [HCNT_W-1:0]   hcount;
      logic [7:0]          value;
      logic [1:0]          oct_left;
      logic                draining;
      logic [7:0]          h0;
      logic [7:0]          h1;
      logic [7:0]          h2;
      logic [3:0]          hexdig;
   } ctx_type;

   typedef struct packed {
      logic                emit;
      logic                emit_valid;
      logic [7:0]          emit_data;
      ptr_op_type          ptr_op;
      logic                set_hold;
   } act_type;

   typedef struct packed {
      logic [4:0]          decode_modes;
      logic [7:0]          stop_char;
      logic [15:0]         max_out_bytes;
   } cfg_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      if (c >= "0" && c <= "9") begin
         t = c - "0";
      end else begin
         t = (c & 8'h0f) + 8'd9;
      end
      return t[3:0];
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

endpackage

>>> sv/eds_if.sv
// ----------------------------------------------------------------------------
// eds channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface eds_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface eds_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       string_end;
   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output string_end, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input string_end, output ready);
endinterface

>>> sv/escape_sequence_decoder_unit.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// percent, plus, equals, backslash and entity escape decoder, one byte step at a time
// ----------------------------------------------------------------------------
//   channel   dir   handshake        payload
//   req       in    valid/ready      in_byte
//   rsp       out   valid/ready      out_byte, byte_valid, run_last, string_end
//   csr       in    apb, pready=1    decode_modes, stop_char, max_out_bytes
//
// each byte step is a buffer read (S_READ) and then a pass through the decode
// unit (S_EXEC); a request of one byte takes a step for the byte and another
// for each replayed byte, and then S_FLUSH hands over the last response before
// the next request is taken. req.ready is high only between requests.
// a full response register stalls the decode step. synchronous reset clears
// the sequencer, pointers and parse state; no clearing pass is needed.
module escape_sequence_decoder_unit
   import eds_pkg::*;
#(
   parameter int ENTITY_NAME_MAX = ENTITY_NAME_MAX_DEF,
   parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   eds_req_if.sink               req,
   eds_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int PTR_W = $clog2(ENTITY_NAME_MAX + 2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
   } res_type;

   state_type              state_ff;
   logic [PTR_W-1:0]       rd_ff, wr_ff, hold_ff;
   logic [PTR_W-1:0]       rd_in;
   ctx_type                ctx_ff, ctx_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   act_type                act;
   cfg_type                cfg;
   logic [7:0]             rd_data;
   logic                   accept;
   logic                   out_free;
   logic                   stall;
   logic                   out_load;
   res_type                pend_ff;
   logic                   pend_v_ff;
   logic                   out_v_ff;
   res_type                out_ff;
   logic                   out_last_ff;

   eds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   eds_buf #(.PTR_W(PTR_W)) u_buf (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_ff),
      .wr_data (req.in_byte),
      .rd_en   (state_ff == S_READ),
      .rd_addr (rd_ff),
      .rd_data (rd_data)
   );

   eds_step #(
      .ENTITY_NAME_MAX (ENTITY_NAME_MAX),
      .COUNT_WIDTH     (COUNT_WIDTH)
   ) u_step (
      .b            (rd_data),
      .cfg          (cfg),
      .ctx          (ctx_ff),
      .out_count    (cnt_ff),
      .ctx_in       (ctx_in),
      .out_count_in (cnt_in),
      .act          (act)
   );

   assign req.ready      = (state_ff == S_IDLE);
   assign accept         = req.valid && req.ready;
   assign out_free       = !out_v_ff || rsp.ready;
   assign stall          = act.emit && pend_v_ff && !out_free;
   assign out_load       = ((state_ff == S_EXEC) && !stall && act.emit && pend_v_ff) ||
                           ((state_ff == S_FLUSH) && pend_v_ff && out_free);
   assign rsp.valid      = out_v_ff;
   assign rsp.out_byte   = out_ff.data;
   assign rsp.byte_valid = out_ff.valid;
   assign rsp.string_end = !out_ff.valid;
   assign rsp.run_last   = out_last_ff;

   always_comb begin
      case (act.ptr_op)
         PTR_REPLAY: rd_in = hold_ff;
         PTR_REDO:   rd_in = rd_ff;
         default:    rd_in = rd_ff + PTR_W'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rd_ff           <= '0;
         wr_ff           <= '0;
         hold_ff         <= '0;
         ctx_ff.parse    <= PS_IDLE;
         ctx_ff.hcount   <= '0;
         ctx_ff.value    <= '0;
         ctx_ff.oct_left <= '0;
         ctx_ff.draining <= 1'b0;
         cnt_ff          <= '0;
         pend_v_ff       <= 1'b0;
         out_v_ff        <= 1'b0;
      end else begin
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (out_v_ff && rsp.ready) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  wr_ff    <= wr_ff + PTR_W'(1);
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (!stall) begin
                  ctx_ff <= ctx_in;
                  cnt_ff <= cnt_in;
                  rd_ff  <= rd_in;
                  if (act.set_hold) begin
                     hold_ff <= rd_ff + PTR_W'(1);
                  end
                  if (act.emit) begin
                     if (pend_v_ff) begin
                        out_ff      <= pend_ff;
                        out_last_ff <= 1'b0;
                     end
                     pend_ff.data  <= act.emit_data;
                     pend_ff.valid <= act.emit_valid;
                     pend_v_ff     <= 1'b1;
                  end
                  state_ff <= (rd_in == wr_ff) ? S_FLUSH : S_READ;
               end
            end
            S_FLUSH: begin
               if (!pend_v_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  out_ff      <= pend_ff;
                  out_last_ff <= 1'b1;
                  pend_v_ff   <= 1'b0;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_ready_no_pend : assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !pend_v_ff)
      else $error("pending response left over at request boundary");

   a_idle_drained : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (rd_ff == wr_ff))
      else $error("unprocessed bytes while idle");

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready && (state_ff == S_READ))
      else $error("request accepted without starting a step");

   a_end_marker : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.string_end |-> (rsp.out_byte == 8'd0))
      else $error("end marker carries data");

endmodule

>>> sv/eds_csr.sv
// ----------------------------------------------------------------------------
// eds_csr
// apb register block: decode modes, stop character, output limit
// ----------------------------------------------------------------------------
module eds_csr
   import eds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] idx;

   assign pready = 1'b1;
   assign idx    = paddr[3:2];
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_modes  <= '0;
         cfg_ff.stop_char     <= '0;
         cfg_ff.max_out_bytes <= MAX_OUT_RESET;
      end else if (wr_en) begin
         case (idx)
            REG_DECODE_MODES:  cfg_ff.decode_modes  <= pwdata[4:0];
            REG_STOP_CHAR:     cfg_ff.stop_char     <= pwdata[7:0];
            REG_MAX_OUT_BYTES: cfg_ff.max_out_bytes <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DECODE_MODES:  prdata = {27'd0, cfg_ff.decode_modes};
         REG_STOP_CHAR:     prdata = {24'd0, cfg_ff.stop_char};
         REG_MAX_OUT_BYTES: prdata = {16'd0, cfg_ff.max_out_bytes};
         default:           prdata = '0;
      endcase
   end

endmodule

>>> sv/eds_buf.sv
// ----------------------------------------------------------------------------
// eds_buf
// byte ring buffer holding pending and lookahead bytes, registered read
// ----------------------------------------------------------------------------
module eds_buf
   import eds_pkg::*;
#(
   parameter int PTR_W = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [PTR_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [2**PTR_W];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> sv/eds_step.sv
// ----------------------------------------------------------------------------
// eds_step
// decode unit for all escape modes: consumes one byte against the parse context
// ----------------------------------------------------------------------------
module eds_step
   import eds_pkg::*;
#(
   parameter int ENTITY_NAME_MAX = ENTITY_NAME_MAX_DEF,
   parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
   input  logic [7:0]             b,
   input  cfg_type                cfg,
   input  ctx_type                ctx,
   input  logic [COUNT_WIDTH-1:0] out_count,
   output ctx_type                ctx_in,
   output logic [COUNT_WIDTH-1:0] out_count_in,
   output act_type                act
);

   localparam logic [31:0] CNT_MASK = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam logic [HCNT_W-1:0] NAME_MAX = HCNT_W'(ENTITY_NAME_MAX);

   logic        term;
   logic        at_limit;
   logic [31:0] cnt_ext;
   logic [31:0] max_ext;
   logic [7:0]  oct_d;

   assign term     = (b == 8'd0) || (b == cfg.stop_char);
   assign cnt_ext  = 32'(out_count);
   assign max_ext  = 32'(cfg.max_out_bytes) & CNT_MASK;
   assign at_limit = cnt_ext >= max_ext;
   assign oct_d    = b - "0";

   always_comb begin
      ctx_in       = ctx;
      act.emit       = 1'b0;
      act.emit_valid = 1'b1;
      act.emit_data  = 8'd0;
      act.ptr_op     = PTR_ADVANCE;
      act.set_hold   = 1'b0;

      case (ctx.parse)
         PS_IDLE: begin
            if (ctx.draining) begin
               if (term) begin
                  ctx_in.draining = 1'b0;
               end
            end else if (term) begin
               act.emit       = 1'b1;
               act.emit_valid = 1'b0;
            end else if (at_limit) begin
               act.emit        = 1'b1;
               act.emit_valid  = 1'b0;
               ctx_in.draining = 1'b1;
            end else if ((b == "%" && cfg.decode_modes[MODE_PERCENT]) ||
                         (b == "+" && cfg.decode_modes[MODE_PLUS]) ||
                         (b == "=" && cfg.decode_modes[MODE_EQUALS])) begin
               ctx_in.value  = b;
               ctx_in.hcount = '0;
               ctx_in.parse  = PS_HEX_A;
               act.set_hold  = 1'b1;
            end else if (b == "\\" && cfg.decode_modes[MODE_BACKSLASH]) begin
               ctx_in.parse = PS_BSL;
            end else if (b == "&" && cfg.decode_modes[MODE_AMPERSAND]) begin
               ctx_in.hcount = '0;
               ctx_in.parse  = PS_AMP;
               act.set_hold  = 1'b1;
            end else begin
               act.emit      = 1'b1;
               act.emit_data = b;
            end
         end
         PS_HEX_A: begin
            if (is_hex(b)) begin
               ctx_in.hexdig = hex_val(b);
               ctx_in.hcount = HCNT_W'(1);
               ctx_in.parse  = PS_HEX_B;
            end else begin
               act.emit      = 1'b1;
               act.emit_data = ctx.value;
               ctx_in.hcount = '0;
               ctx_in.parse  = PS_IDLE;
               act.ptr_op    = PTR_REPLAY;
            end
         end
         PS_HEX_B: begin
            act.emit      = 1'b1;
            ctx_in.hcount = '0;
            ctx_in.parse  = PS_IDLE;
            if (is_hex(b) && ctx.hcount == HCNT_W'(1)) begin
               act.emit_data = {ctx.hexdig, hex_val(b)};
            end else begin
               act.emit_data = ctx.value;
               act.ptr_op    = PTR_REPLAY;
            end
         end
         PS_BSL: begin
            ctx_in.parse = PS_IDLE;
            act.emit     = 1'b1;
            case (b)
               "a":  act.emit_data = 8'd7;
               "b":  act.emit_data = 8'd8;
               "n":  act.emit_data = 8'd10;
               "f":  act.emit_data = 8'd12;
               "r":  act.emit_data = 8'd13;
               "v":  act.emit_data = 8'd11;
               "\\", "'", "\"": act.emit_data = b;
               "x": begin
                  act.emit      = 1'b0;
                  ctx_in.value  = "x";
                  ctx_in.hcount = '0;
                  ctx_in.parse  = PS_HEX_A;
                  act.set_hold  = 1'b1;
               end
               default: begin
                  if (is_oct(b)) begin
                     act.emit        = 1'b0;
                     ctx_in.value    = oct_d;
                     ctx_in.oct_left = 2'd2;
                     ctx_in.parse    = PS_OCT;
                  end else begin
                     act.emit_data = "\\";
                     act.ptr_op    = PTR_REDO;
                  end
               end
            endcase
         end
         PS_OCT: begin
            if (is_oct(b) && ctx.oct_left != 2'd0) begin
               ctx_in.value    = {ctx.value[4:0], oct_d[2:0]};
               ctx_in.oct_left = ctx.oct_left - 2'd1;
               if (ctx.oct_left == 2'd1) begin
                  act.emit      = 1'b1;
                  act.emit_data = {ctx.value[4:0], oct_d[2:0]};
                  ctx_in.parse  = PS_IDLE;
               end
            end else begin
               act.emit        = 1'b1;
               act.emit_data   = ctx.value;
               ctx_in.oct_left = 2'd0;
               ctx_in.parse    = PS_IDLE;
               act.ptr_op      = PTR_REDO;
            end
         end
         PS_AMP: begin
            if (b == ";") begin
               if (ctx.hcount == HCNT_W'(3) && ctx.h0 == "a" && ctx.h1 == "m" &&
                   ctx.h2 == "p") begin
                  act.emit      = 1'b1;
                  act.emit_data = "&";
               end else if (ctx.hcount == HCNT_W'(2) && ctx.h0 == "g" && ctx.h1 == "t") begin
                  act.emit      = 1'b1;
                  act.emit_data = ">";
               end else if (ctx.hcount == HCNT_W'(2) && ctx.h0 == "l" && ctx.h1 == "t") begin
                  act.emit      = 1'b1;
                  act.emit_data = "<";
               end
               ctx_in.hcount = '0;
               ctx_in.parse  = PS_IDLE;
            end else if (b == 8'd0 || ctx.hcount >= NAME_MAX) begin
               act.emit      = 1'b1;
               act.emit_data = "&";
               ctx_in.hcount = '0;
               ctx_in.parse  = PS_IDLE;
               act.ptr_op    = PTR_REPLAY;
            end else begin
               case (ctx.hcount)
                  HCNT_W'(0): ctx_in.h0 = b;
                  HCNT_W'(1): ctx_in.h1 = b;
                  HCNT_W'(2): ctx_in.h2 = b;
                  default: ;
               endcase
               ctx_in.hcount = ctx.hcount + HCNT_W'(1);
            end
         end
         default: begin
            ctx_in.parse = PS_IDLE;
         end
      endcase
   end

   always_comb begin
      if (act.emit && !act.emit_valid) begin
         out_count_in = '0;
      end else if (act.emit) begin
         out_count_in = out_count + COUNT_WIDTH'(1);
      end else begin
         out_count_in = out_count;
      end
   end

endmodule
